### hw/rtl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared constants, codes and payload types of the repair remap table.
// ----------------------------------------------------------------------------
package rrc_pkg;

    // Table geometry
    localparam int CAPACITY     = 64;
    localparam int WORD_BITS    = 32;
    localparam int ROW_BITS     = 16;
    localparam int COL_BITS     = 10;
    localparam int CHANNEL_BITS = 3;

    localparam int KEY_W = CHANNEL_BITS + ROW_BITS + COL_BITS;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // width that holds both the chunk register and the capacity
    localparam int PW    = (CNT_W > 7) ? CNT_W : 7;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    // Search modes
    localparam logic [1:0] MODE_ALL     = 2'd0;
    localparam logic [1:0] MODE_SINGLE  = 2'd1;
    localparam logic [1:0] MODE_CHUNKED = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_SEARCH_MODE = 1'b0;
    localparam logic REG_CHUNK_PAR   = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  channel;
        logic [15:0] row;
        logic [9:0]  col;
        logic [31:0] word_in;
    } rrc_req_t;

    typedef struct packed {
        logic        hit;
        logic        full_res;
        logic [5:0]  match_index;
        logic [31:0] word_out;
        logic [6:0]  rounds;
        logic [6:0]  compared;
        logic [6:0]  occupied;
    } rrc_res_t;

    // Memory port requests from the sequencer
    typedef struct packed {
        logic                 key_rd;
        logic [IDX_W-1:0]     key_rd_addr;
        logic                 key_wr;
        logic                 word_wr;
        logic                 word_rd;
        logic [IDX_W-1:0]     fin_addr;
        logic [KEY_W-1:0]     wr_key;
        logic [WORD_BITS-1:0] wr_word;
    } rrc_mem_req_t;

endpackage

### hw/rtl/repair_remap_table_chunked_cam.sv
// ----------------------------------------------------------------------------
// repair_remap_table_chunked_cam
// Repair remap table: key and data stores, config registers and the scan
// sequencer that does insert, read and write lookups.
// ----------------------------------------------------------------------------
//  channel   signals                              handshake
//  -------   ----------------------------------   ----------------------------
//  request   start, busy, req (op/key/word_in)     taken when start && !busy
//  result    done, res                            one-cycle strobe, no stall
//  config    psel, penable, pwrite, paddr, pwdata  APB write, pready tied high
//
//  The scan reads one key store entry per cycle through one comparator.
//  A read or write that hits slot j stops the scan there and delivers its
//  item; a miss or an insert scans every slot, and op three skips the scan.
//  The block is busy until done; results cannot be held off by the receiver.
//  Reset clears all valid bits and occupancy at once; no clearing pass.
// ----------------------------------------------------------------------------
module repair_remap_table_chunked_cam import rrc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  rrc_req_t    req,
    output logic        done,
    output rrc_res_t    res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]           search_mode_reg;
    logic [6:0]           chunk_par_reg;
    logic                 cfg_wr;
    rrc_mem_req_t         mem_req;
    logic [KEY_W-1:0]     key_rdata;
    logic [WORD_BITS-1:0] word_rdata;

    // Config registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_mode_reg <= MODE_CHUNKED;
            chunk_par_reg   <= 7'd8;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_SEARCH_MODE: search_mode_reg <= pwdata[1:0];
                REG_CHUNK_PAR:   chunk_par_reg   <= pwdata[6:0];
                default:         chunk_par_reg   <= chunk_par_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SEARCH_MODE: prdata = 32'(search_mode_reg);
            REG_CHUNK_PAR:   prdata = 32'(chunk_par_reg);
            default:         prdata = '0;
        endcase
    end

    // Key store
    rrc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (mem_req.key_wr),
        .wr_addr (mem_req.fin_addr),
        .wr_data (mem_req.wr_key),
        .rd_en   (mem_req.key_rd),
        .rd_addr (mem_req.key_rd_addr),
        .rd_data (key_rdata)
    );

    // Data store
    rrc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_word_ram (
        .clk     (clk),
        .wr_en   (mem_req.word_wr),
        .wr_addr (mem_req.fin_addr),
        .wr_data (mem_req.wr_word),
        .rd_en   (mem_req.word_rd),
        .rd_addr (mem_req.fin_addr),
        .rd_data (word_rdata)
    );

    rrc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .req         (req),
        .res         (res),
        .search_mode (search_mode_reg),
        .chunk_par   (chunk_par_reg),
        .mem_req     (mem_req),
        .key_rdata   (key_rdata),
        .word_rdata  (word_rdata)
    );

endmodule

### hw/rtl/rrc_ram.sv
// ----------------------------------------------------------------------------
// rrc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/rrc_seq.sv
// ----------------------------------------------------------------------------
// rrc_seq
// Scan sequencer: walks the key store one slot per cycle through a single
// key comparator, keeps valid bits, occupancy and round/compare counters.
// ----------------------------------------------------------------------------
module rrc_seq import rrc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    input  rrc_req_t         req,
    output rrc_res_t         res,
    input  logic [1:0]       search_mode,
    input  logic [6:0]       chunk_par,
    output rrc_mem_req_t     mem_req,
    input  logic [KEY_W-1:0] key_rdata,
    input  logic [WORD_BITS-1:0] word_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [PW-1:0]    CAP_P    = PW'(CAPACITY);

    logic [1:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [IDX_W-1:0]     issue_addr_reg, issue_addr_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 cmp_slot_vld_reg, cmp_slot_vld_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]     rounds_reg, rounds_next;
    logic [CNT_W-1:0]     compared_reg, compared_next;
    logic                 match_found_reg, match_found_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [CAPACITY-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic                 hit_reg, hit_next;
    logic                 full_reg, full_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;

    logic                 accept;
    logic                 is_lookup;
    logic                 key_rd;
    logic                 slot_hit;
    logic                 last_slot;
    logic [PW-1:0]        per_round;
    logic [IDX_W-1:0]     fin_addr;
    logic                 key_wr;
    logic                 word_wr;
    logic                 word_rd;
    logic [WORD_BITS-1:0] word_out;

    assign accept    = start && (state_reg == S_IDLE);
    assign is_lookup = (op_reg == OP_READ) || (op_reg == OP_WRITE);
    assign key_rd    = (state_reg == S_SCAN) && !issue_done_reg;

    // Shared comparator on the slot read last cycle
    assign slot_hit  = cmp_vld_reg && cmp_slot_vld_reg && (key_rdata == key_reg);
    assign last_slot = (cmp_idx_reg == LAST_IDX);

    // Slots per round
    always_comb
    begin
        case (search_mode)
            MODE_ALL:    per_round = CAP_P;
            MODE_SINGLE: per_round = PW'(1);
            default:
            begin
                if (chunk_par == 7'd0)
                    per_round = PW'(1);
                else if (PW'(chunk_par) > CAP_P)
                    per_round = CAP_P;
                else
                    per_round = PW'(chunk_par);
            end
        endcase
    end

    // Slot touched at the finish step
    always_comb
    begin
        if ((op_reg == OP_INSERT) && !match_found_reg)
            fin_addr = free_idx_reg;
        else
            fin_addr = match_idx_reg;
    end

    assign key_wr  = (state_reg == S_FIN) && (op_reg == OP_INSERT)
                     && !match_found_reg && free_found_reg;
    assign word_wr = (state_reg == S_FIN)
                     && (((op_reg == OP_INSERT) && (match_found_reg || free_found_reg))
                         || ((op_reg == OP_WRITE) && match_found_reg));
    assign word_rd = (state_reg == S_FIN) && (op_reg == OP_READ) && match_found_reg;

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        word_next         = word_reg;
        issue_addr_next   = issue_addr_reg;
        issue_done_next   = issue_done_reg;
        cmp_vld_next      = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        cmp_slot_vld_next = cmp_slot_vld_reg;
        pos_next          = pos_reg;
        rounds_next       = rounds_reg;
        compared_next     = compared_reg;
        match_found_next  = match_found_reg;
        match_idx_next    = match_idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        valid_next        = valid_reg;
        occ_next          = occ_reg;
        hit_next          = hit_reg;
        full_next         = full_reg;
        idx_next          = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next          = req.op;
                    key_next         = {req.channel[CHANNEL_BITS-1:0],
                                        req.row[ROW_BITS-1:0],
                                        req.col[COL_BITS-1:0]};
                    word_next        = req.word_in[WORD_BITS-1:0];
                    issue_addr_next  = '0;
                    issue_done_next  = 1'b0;
                    pos_next         = '0;
                    rounds_next      = '0;
                    compared_next    = '0;
                    match_found_next = 1'b0;
                    match_idx_next   = '0;
                    free_found_next  = 1'b0;
                    free_idx_next    = '0;
                    hit_next         = 1'b0;
                    full_next        = 1'b0;
                    idx_next         = '0;
                    // undefined op: straight to the result
                    if ((req.op == OP_INSERT) || (req.op == OP_READ)
                        || (req.op == OP_WRITE))
                        state_next = S_SCAN;
                    else
                        state_next = S_OUT;
                end
            end

            S_SCAN:
            begin
                // issue stage: one key read per cycle
                if (key_rd)
                begin
                    cmp_vld_next      = 1'b1;
                    cmp_idx_next      = issue_addr_reg;
                    cmp_slot_vld_next = valid_reg[issue_addr_reg];
                    if (issue_addr_reg == LAST_IDX)
                        issue_done_next = 1'b1;
                    else
                        issue_addr_next = issue_addr_reg + 1'b1;
                end

                // compare stage
                if (cmp_vld_reg)
                begin
                    if (is_lookup)
                    begin
                        if (cmp_slot_vld_reg)
                            compared_next = compared_reg + 1'b1;
                        if (pos_reg == '0)
                            rounds_next = rounds_reg + 1'b1;
                        if (pos_reg + 1'b1 == per_round)
                            pos_next = '0;
                        else
                            pos_next = pos_reg + 1'b1;
                        if (slot_hit)
                        begin
                            match_found_next = 1'b1;
                            match_idx_next   = cmp_idx_reg;
                        end
                        if (slot_hit || last_slot)
                        begin
                            state_next   = S_FIN;
                            cmp_vld_next = 1'b0;
                        end
                    end
                    else
                    begin
                        if (slot_hit && !match_found_reg)
                        begin
                            match_found_next = 1'b1;
                            match_idx_next   = cmp_idx_reg;
                        end
                        if (!cmp_slot_vld_reg && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (last_slot)
                        begin
                            state_next   = S_FIN;
                            cmp_vld_next = 1'b0;
                        end
                    end
                end
            end

            S_FIN:
            begin
                if (op_reg == OP_INSERT)
                begin
                    hit_next  = match_found_reg || free_found_reg;
                    full_next = !(match_found_reg || free_found_reg);
                    idx_next  = (match_found_reg || free_found_reg) ? fin_addr : '0;
                end
                else
                begin
                    hit_next = match_found_reg;
                    idx_next = match_found_reg ? match_idx_reg : '0;
                end
                if (key_wr)
                begin
                    valid_next[fin_addr] = 1'b1;
                    occ_next             = occ_reg + 1'b1;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
            valid_reg   <= '0;
            occ_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            valid_reg   <= valid_next;
            occ_reg     <= occ_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        key_reg          <= key_next;
        word_reg         <= word_next;
        issue_addr_reg   <= issue_addr_next;
        issue_done_reg   <= issue_done_next;
        cmp_idx_reg      <= cmp_idx_next;
        cmp_slot_vld_reg <= cmp_slot_vld_next;
        pos_reg          <= pos_next;
        rounds_reg       <= rounds_next;
        compared_reg     <= compared_next;
        match_found_reg  <= match_found_next;
        match_idx_reg    <= match_idx_next;
        free_found_reg   <= free_found_next;
        free_idx_reg     <= free_idx_next;
        hit_reg          <= hit_next;
        full_reg         <= full_next;
        idx_reg          <= idx_next;
    end

    // Result word
    always_comb
    begin
        case (op_reg)
            OP_READ:  word_out = hit_reg ? word_rdata : word_reg;
            OP_WRITE: word_out = hit_reg ? word_reg : '0;
            default:  word_out = '0;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

    assign res.hit         = hit_reg;
    assign res.full_res    = full_reg;
    assign res.match_index = 6'(idx_reg);
    assign res.word_out    = 32'(word_out);
    assign res.rounds      = 7'(rounds_reg);
    assign res.compared    = 7'(compared_reg);
    assign res.occupied    = 7'(occ_reg);

    assign mem_req.key_rd      = key_rd;
    assign mem_req.key_rd_addr = issue_addr_reg;
    assign mem_req.key_wr      = key_wr;
    assign mem_req.word_wr     = word_wr;
    assign mem_req.word_rd     = word_rd;
    assign mem_req.fin_addr    = fin_addr;
    assign mem_req.wr_key      = key_reg;
    assign mem_req.wr_word     = word_reg;

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not make the block busy");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after delivering an item");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && full_reg) |-> (occ_reg == CNT_W'(CAPACITY)))
        else $error("insert rejected while a slot was free");

    a_hit_full_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit_reg && full_reg))
        else $error("hit and full flagged together");

endmodule

### dv/tb_repair_remap_table_chunked_cam.sv
// ----------------------------------------------------------------------------
// tb_repair_remap_table_chunked_cam
// Self-checking bench for the repair remap table. Items go in through the
// start/busy port, and every result strobe is checked against a table model
// kept in a scoreboard. The search mode and chunk size are changed over the
// run through the APB port while the table fills up and then runs full.
// ----------------------------------------------------------------------------
module tb_repair_remap_table_chunked_cam;
    import rrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package leaves out
    localparam logic [1:0] MODE_ODD     = 2'd3;
    localparam logic [1:0] OP_NOP       = 2'd3;

    localparam logic [KEY_W-1:0] KEY_LO  = '0;
    localparam logic [KEY_W-1:0] KEY_HI  = '1;
    localparam logic [KEY_W-1:0] KEY_CH7 = {3'd7, 16'd0, 10'd0};

    localparam int POOL_SIZE  = 72;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_LEN  = 135;

    // ------------------------------------------------------------------------
    // Scoreboard: table model and queue of expected results
    // ------------------------------------------------------------------------
    class remap_scoreboard;
        bit               slot_vld [CAPACITY];
        logic [KEY_W-1:0] slot_key [CAPACITY];
        logic [31:0]      slot_word[CAPACITY];
        logic [1:0]       mode;
        logic [6:0]       chunk;
        rrc_res_t         expected_q[$];
        int               errors;

        function new();
            foreach (slot_vld[i]) slot_vld[i] = 1'b0;
            mode   = MODE_CHUNKED;
            chunk  = 7'd8;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_SEARCH_MODE)
                mode = value[1:0];
            else
                chunk = value[6:0];
        endfunction

        function int round_size();
            int p;
            if (mode == MODE_ALL)
                return CAPACITY;
            if (mode == MODE_SINGLE)
                return 1;
            // chunked and the odd mode alike; zero chunk means one slot
            p = (chunk == 7'd0) ? 1 : int'(chunk);
            return (p > CAPACITY) ? CAPACITY : p;
        endfunction

        // Apply one accepted item to the model and queue its result
        function void note_item(rrc_req_t r);
            rrc_res_t         e;
            logic [KEY_W-1:0] key;
            int               p, nrounds, ncmp, idx, stop, j, b, n;
            bit               found;
            e       = '0;
            key     = {r.channel, r.row, r.col};
            idx     = 0;
            nrounds = 0;
            ncmp    = 0;
            n       = 0;
            found   = 1'b0;
            case (r.op)
                OP_INSERT: begin
                    // update a matching entry, else take the lowest free slot
                    for (j = 0; j < CAPACITY && !found; j++)
                        if (slot_vld[j] && slot_key[j] == key) begin
                            slot_word[j] = r.word_in;
                            idx = j;
                            found = 1'b1;
                        end
                    for (j = 0; j < CAPACITY && !found; j++)
                        if (!slot_vld[j]) begin
                            slot_vld[j]  = 1'b1;
                            slot_key[j]  = key;
                            slot_word[j] = r.word_in;
                            idx = j;
                            found = 1'b1;
                        end
                    e.hit      = found;
                    e.full_res = !found;
                end
                OP_READ, OP_WRITE: begin
                    p = round_size();
                    for (b = 0; b < CAPACITY && !found; b += p) begin
                        nrounds++;
                        stop = (b + p > CAPACITY) ? CAPACITY : b + p;
                        for (j = b; j < stop && !found; j++)
                            if (slot_vld[j]) begin
                                ncmp++;
                                if (slot_key[j] == key) begin
                                    found = 1'b1;
                                    idx = j;
                                end
                            end
                    end
                    e.hit = found;
                    if (r.op == OP_READ)
                        e.word_out = found ? slot_word[idx] : r.word_in;
                    else if (found) begin
                        slot_word[idx] = r.word_in;
                        e.word_out = r.word_in;
                    end
                end
                default: ;
            endcase
            foreach (slot_vld[i]) if (slot_vld[i]) n++;
            e.match_index = idx[5:0];
            e.rounds      = nrounds[6:0];
            e.compared    = ncmp[6:0];
            e.occupied    = n[6:0];
            expected_q    = {expected_q, e};
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(rrc_res_t a);
            rrc_res_t e;
            if (expected_q.size() == 0) begin
                $error("result strobe with no item outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            check_field("hit",         32'(e.hit),         32'(a.hit));
            check_field("full_res",    32'(e.full_res),    32'(a.full_res));
            check_field("match_index", 32'(e.match_index), 32'(a.match_index));
            check_field("word_out",    e.word_out,         a.word_out);
            check_field("rounds",      32'(e.rounds),      32'(a.rounds));
            check_field("compared",    32'(e.compared),    32'(a.compared));
            check_field("occupied",    32'(e.occupied),    32'(a.occupied));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rrc_req_t    req;
    logic        done;
    rrc_res_t    res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    repair_remap_table_chunked_cam DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    remap_scoreboard sb = new();

    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(res);
    end

    // ------------------------------------------------------------------------
    // Drivers; every task starts and returns at a falling edge
    // ------------------------------------------------------------------------
    function automatic rrc_req_t make_req(logic [1:0] op, logic [KEY_W-1:0] key,
                                          logic [31:0] word);
        rrc_req_t r;
        r.op = op;
        {r.channel, r.row, r.col} = key;
        r.word_in = word;
        return r;
    endfunction

    // Present one item, hold it until taken, then idle for the requested gap
    task automatic send_item(rrc_req_t r, int gap);
        req   = r;
        start = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(r);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold off until every outstanding result is back and the block is free
    task automatic drain();
        start = 1'b0;
        while (sb.outstanding() != 0 || busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Both registers, junk in the unused upper bits
    task automatic configure(logic [1:0] m, logic [6:0] p);
        drain();
        repeat (3) @(negedge clk);
        write_reg(REG_SEARCH_MODE, {30'($urandom), m});
        write_reg(REG_CHUNK_PAR, {25'($urandom), p});
    endtask

    // Mostly short gaps, some long ones, none at all when busy_run is set
    function automatic int pick_gap(bit busy_run);
        int s;
        if (busy_run)
            return 0;
        s = $urandom_range(0, 99);
        if (s < 50)
            return 0;
        if (s < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Random item: known keys, near misses and stray keys
    function automatic rrc_req_t random_item(int pool_lim);
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [31:0]      word;
        int               s, k;
        s = $urandom_range(0, 99);
        if (s < 30)
            op = OP_INSERT;
        else if (s < 63)
            op = OP_READ;
        else if (s < 95)
            op = OP_WRITE;
        else
            op = OP_NOP;
        // stray-key inserts are kept rare so the table fills gradually
        k = $urandom_range(0, (op == OP_INSERT) ? 88 : 99);
        key = key_pool[$urandom_range(0, pool_lim - 1)];
        if (k >= 82)
            key = KEY_W'($urandom);
        else if (k >= 70)
            key = key ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
        s = $urandom_range(0, 99);
        if (s < 3)
            word = '0;
        else if (s < 6)
            word = '1;
        else
            word = $urandom;
        return make_req(op, key, word);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [1:0] phase_mode[NUM_PHASES];
        logic [6:0] phase_chunk[NUM_PHASES];
        int         lim;
        bit         busy_run;

        phase_mode  = '{MODE_CHUNKED, MODE_SINGLE, MODE_ALL, MODE_CHUNKED,
                        MODE_ODD, MODE_CHUNKED, MODE_CHUNKED, MODE_SINGLE};
        phase_chunk = '{7'd8, 7'd1, 7'd64, 7'd0, 7'd5, 7'd127, 7'd3, 7'd64};

        rst_n   = 1'b0;
        start   = 1'b0;
        req     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table, extreme keys and words, update, no-op
        send_item(make_req(OP_READ,   KEY_LO, '1), 0);
        send_item(make_req(OP_WRITE,  KEY_LO, 32'h1234_5678), 0);
        send_item(make_req(OP_NOP,    KEY_HI, '1), 2);
        send_item(make_req(OP_INSERT, KEY_LO, '0), 0);
        send_item(make_req(OP_INSERT, KEY_HI, '1), 1);
        send_item(make_req(OP_READ,   KEY_LO, '1), 0);
        send_item(make_req(OP_READ,   KEY_HI, '0), 0);
        send_item(make_req(OP_WRITE,  KEY_HI, 32'h5A5A_A5A5), 3);
        send_item(make_req(OP_READ,   KEY_HI, '0), 0);
        send_item(make_req(OP_INSERT, KEY_LO, 32'hDEAD_BEEF), 0);
        send_item(make_req(OP_READ,   KEY_LO, '0), 0);
        send_item(make_req(OP_READ,   KEY_CH7, 32'h0F0F_0F0F), 0);
        send_item(make_req(OP_WRITE,  KEY_CH7, '1), 0);
        send_item(make_req(OP_NOP,    KEY_LO, '0), 0);

        // Directed: every search mode and the chunk extremes
        configure(MODE_ALL, 7'd8);
        send_item(make_req(OP_READ, KEY_HI, '0), 0);
        send_item(make_req(OP_READ, KEY_CH7, 32'h1), 0);
        configure(MODE_SINGLE, 7'd8);
        send_item(make_req(OP_READ, KEY_HI, '0), 0);
        send_item(make_req(OP_WRITE, KEY_CH7, 32'h2), 0);
        configure(MODE_ODD, 7'd0);
        send_item(make_req(OP_READ, KEY_HI, '0), 0);
        configure(MODE_CHUNKED, 7'd127);
        send_item(make_req(OP_READ, KEY_CH7, 32'h3), 0);
        send_item(make_req(OP_WRITE, KEY_LO, 32'h4), 0);

        // Random phases; the key pool widens so the table ends up full
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            configure(phase_mode[ph], phase_chunk[ph]);
            lim = 8 + ph * 10;
            if (lim > POOL_SIZE)
                lim = POOL_SIZE;
            busy_run = 1'b0;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // stretches with and without idle cycles, chosen at random
                if (n % 40 == 0)
                    busy_run = ($urandom_range(0, 2) == 0);
                send_item(random_item(lim), pick_gap(busy_run));
                if ($urandom_range(0, 59) == 0)
                    drain();
            end
        end

        // Wind down
        drain();
        repeat (CAPACITY + 10) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            $error("%0d expected results never arrived", sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
